FILE: sv/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
package lpg_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SIDE_W  = 12;
  localparam int unsigned ADDR_W  = 22;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIDE_W-1:0]         side_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  // Input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam side_t SCREEN_WIDTH_RST  = 12'd700;
  localparam side_t SCREEN_HEIGHT_RST = 12'd700;

  // One walker result on its way to address generation
  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

endpackage

FILE: sv/lpg_if.sv
// Valid/ready channel interfaces for line commands and pixel results.
interface lpg_cmd_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  lpg_pkg::coord_t start_x;
  lpg_pkg::coord_t start_y;
  lpg_pkg::coord_t end_x;
  lpg_pkg::coord_t end_y;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lpg_pix_if;
  logic            valid;
  logic            ready;
  logic            pixel_valid;
  lpg_pkg::coord_t pixel_x;
  lpg_pkg::coord_t pixel_y;
  logic            write_enable;
  lpg_pkg::addr_t  write_address;
  logic            last_pixel;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, write_enable,
                  write_address, last_pixel, input ready);
  modport sink   (input valid, pixel_valid, pixel_x, pixel_y, write_enable,
                  write_address, last_pixel, output ready);
endinterface

FILE: sv/lpg_walker.sv
// Bresenham walker: line state, per-command update and the first pipeline register.
module lpg_walker (
  input  logic              clk,
  input  logic              rst,
  lpg_cmd_if.sink           cmd_ch,
  output lpg_pkg::pixel_t   s1_pix,
  output logic              s1_valid,
  input  logic              s2_ready
);

  logic                line_active, line_active_next;
  lpg_pkg::coord_t     cur_x, cur_x_next;
  lpg_pkg::coord_t     cur_y, cur_y_next;
  lpg_pkg::coord_t     major_end, major_end_next;
  logic signed [14:0]  decision, decision_next;
  logic [12:0]         abs_dx, abs_dx_next;
  logic [12:0]         abs_dy, abs_dy_next;
  logic                x_major, x_major_next;
  logic                minor_neg, minor_neg_next;
  lpg_pkg::pixel_t     pix_next;

  logic signed [12:0]  dx, dy;
  logic [12:0]         adx, ady;
  logic                same_dir, xmaj_new;
  logic [14:0]         adx2, ady2, st_adx2, st_ady2;
  lpg_pkg::coord_t     minor_step;
  logic                last;
  logic                accept;

  assign cmd_ch.ready = !s1_valid || s2_ready;
  assign accept       = cmd_ch.valid && cmd_ch.ready;

  always_comb begin
    line_active_next = line_active;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    major_end_next   = major_end;
    decision_next    = decision;
    abs_dx_next      = abs_dx;
    abs_dy_next      = abs_dy;
    x_major_next     = x_major;
    minor_neg_next   = minor_neg;
    pix_next         = '0;
    last             = 1'b0;

    dx       = {cmd_ch.end_x[11], cmd_ch.end_x} - {cmd_ch.start_x[11], cmd_ch.start_x};
    dy       = {cmd_ch.end_y[11], cmd_ch.end_y} - {cmd_ch.start_y[11], cmd_ch.start_y};
    adx      = dx[12] ? (~dx + 13'd1) : dx;
    ady      = dy[12] ? (~dy + 13'd1) : dy;
    same_dir = (!dx[12] && dx != '0 && !dy[12] && dy != '0) || (dx[12] && dy[12]);
    xmaj_new = ady <= adx;
    st_adx2  = {1'b0, adx, 1'b0};
    st_ady2  = {1'b0, ady, 1'b0};

    adx2       = {1'b0, abs_dx, 1'b0};
    ady2       = {1'b0, abs_dy, 1'b0};
    minor_step = minor_neg ? -12'sd1 : 12'sd1;

    if (cmd_ch.cmd == lpg_pkg::CMD_START) begin
      abs_dx_next    = adx;
      abs_dy_next    = ady;
      x_major_next   = xmaj_new;
      minor_neg_next = !same_dir;
      if (xmaj_new) begin
        decision_next = $signed(st_ady2 - {2'b00, adx});
        if (!dx[12]) begin
          cur_x_next = cmd_ch.start_x; cur_y_next = cmd_ch.start_y;
          major_end_next = cmd_ch.end_x;
        end else begin
          cur_x_next = cmd_ch.end_x; cur_y_next = cmd_ch.end_y;
          major_end_next = cmd_ch.start_x;
        end
        last = cur_x_next >= major_end_next;
      end else begin
        decision_next = $signed(st_adx2 - {2'b00, ady});
        if (!dy[12]) begin
          cur_x_next = cmd_ch.start_x; cur_y_next = cmd_ch.start_y;
          major_end_next = cmd_ch.end_y;
        end else begin
          cur_x_next = cmd_ch.end_x; cur_y_next = cmd_ch.end_y;
          major_end_next = cmd_ch.start_y;
        end
        last = cur_y_next >= major_end_next;
      end
      line_active_next     = !last;
      pix_next.pixel_valid = 1'b1;
      pix_next.pixel_x     = cur_x_next;
      pix_next.pixel_y     = cur_y_next;
      pix_next.last_pixel  = last;
    end else if (line_active) begin
      if (x_major) begin
        cur_x_next = cur_x + 12'sd1;
        if (decision[14]) begin
          decision_next = decision + $signed(ady2);
        end else begin
          cur_y_next    = cur_y + minor_step;
          decision_next = decision + $signed(ady2 - adx2);
        end
        last = cur_x_next >= major_end;
      end else begin
        cur_y_next = cur_y + 12'sd1;
        // y-major steps the minor axis only on a strictly positive decision
        if (decision[14] || decision == '0) begin
          decision_next = decision + $signed(adx2);
        end else begin
          cur_x_next    = cur_x + minor_step;
          decision_next = decision + $signed(adx2 - ady2);
        end
        last = cur_y_next >= major_end;
      end
      line_active_next     = !last;
      pix_next.pixel_valid = 1'b1;
      pix_next.pixel_x     = cur_x_next;
      pix_next.pixel_y     = cur_y_next;
      pix_next.last_pixel  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      major_end   <= '0;
      decision    <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      x_major     <= 1'b0;
      minor_neg   <= 1'b0;
    end else if (accept) begin
      line_active <= line_active_next;
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      major_end   <= major_end_next;
      decision    <= decision_next;
      abs_dx      <= abs_dx_next;
      abs_dy      <= abs_dy_next;
      x_major     <= x_major_next;
      minor_neg   <= minor_neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      s1_valid <= cmd_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix_next;
    end
  end

endmodule

FILE: sv/lpg_addr.sv
// Screen clip and frame-buffer address: clip stage, then multiply-add into the result register.
module lpg_addr #(
  parameter int unsigned MAX_SIDE = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  lpg_pkg::pixel_t   s1_pix,
  input  logic              s1_valid,
  output logic              s2_ready,
  input  lpg_pkg::side_t    screen_width,
  input  lpg_pkg::side_t    screen_height,
  lpg_pix_if.source         pix_ch
);

  lpg_pkg::side_t  w_eff, h_eff;
  logic            in_screen;
  lpg_pkg::side_t  row;

  logic            s2_valid;
  lpg_pkg::pixel_t s2_pix;
  logic            s2_we;
  lpg_pkg::side_t  s2_row;
  logic            s3_ready;
  logic [23:0]     prod_sum;

  // Sides above MAX_SIDE saturate
  assign w_eff = (32'(screen_width) > MAX_SIDE) ? lpg_pkg::side_t'(MAX_SIDE) : screen_width;
  assign h_eff = (32'(screen_height) > MAX_SIDE) ? lpg_pkg::side_t'(MAX_SIDE) : screen_height;

  assign in_screen = s1_pix.pixel_valid
               && !s1_pix.pixel_x[11] && (lpg_pkg::side_t'(s1_pix.pixel_x) < w_eff)
               && !s1_pix.pixel_y[11] && (lpg_pkg::side_t'(s1_pix.pixel_y) < h_eff);
  // Row flip: bottom row of the screen is address row zero
  assign row = h_eff - 12'd1 - lpg_pkg::side_t'(s1_pix.pixel_y);

  assign s3_ready = !pix_ch.valid || pix_ch.ready;
  assign s2_ready = !s2_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_pix <= s1_pix;
      s2_we  <= in_screen;
      s2_row <= row;
    end
  end

  assign prod_sum = (24'(s2_row) * 24'(w_eff)) + 24'(lpg_pkg::side_t'(s2_pix.pixel_x));

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (s3_ready) begin
      pix_ch.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      pix_ch.pixel_valid   <= s2_pix.pixel_valid;
      pix_ch.pixel_x       <= s2_pix.pixel_x;
      pix_ch.pixel_y       <= s2_pix.pixel_y;
      pix_ch.last_pixel    <= s2_pix.last_pixel;
      pix_ch.write_enable  <= s2_we;
      pix_ch.write_address <= s2_we ? prod_sum[21:0] : '0;
    end
  end

endmodule

FILE: sv/line_pixel_generator_core.sv
// Top level of the line pixel generator: config registers, walker and address pipeline.
// A start command (cmd=0) loads two endpoints and returns the first pixel of the line
// from the endpoint lower on the major axis; each step command (cmd=1) returns the
// next pixel, or a result with pixel_valid=0 and all fields zero when no line is
// active. Each result carries a write enable (pixel inside the configured screen)
// and the row-flipped frame-buffer address (height-1-y)*width+x. One command is
// taken every clock while the result channel gives no back-pressure; a result
// passes through the walker register, the clip register and the multiply-add
// result register in turn. Screen sides above MAX_SIDE saturate to MAX_SIDE;
// change them only while no command is in flight.
module line_pixel_generator_core #(
  parameter int unsigned MAX_SIDE = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_index,
  input  lpg_pkg::side_t    cfg_data,
  lpg_cmd_if.sink           cmd_ch,
  lpg_pix_if.source         pix_ch
);

  lpg_pkg::side_t  screen_width;
  lpg_pkg::side_t  screen_height;
  lpg_pkg::pixel_t s1_pix;
  logic            s1_valid;
  logic            s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lpg_pkg::SCREEN_WIDTH_RST;
      screen_height <= lpg_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        lpg_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        lpg_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lpg_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .cmd_ch   (cmd_ch),
    .s1_pix   (s1_pix),
    .s1_valid (s1_valid),
    .s2_ready (s2_ready)
  );

  lpg_addr #(
    .MAX_SIDE (MAX_SIDE)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .s1_pix        (s1_pix),
    .s1_valid      (s1_valid),
    .s2_ready      (s2_ready),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pix_ch        (pix_ch)
  );

`ifndef NO_ASSERTIONS
  a_addr_zero_off_screen: assert property (@(posedge clk) disable iff (rst)
    pix_ch.valid && !pix_ch.write_enable |-> pix_ch.write_address == '0)
    else $error("address nonzero for a pixel outside the screen");

  a_empty_result_clear: assert property (@(posedge clk) disable iff (rst)
    pix_ch.valid && !pix_ch.pixel_valid |->
      !pix_ch.write_enable && !pix_ch.last_pixel &&
      pix_ch.pixel_x == '0 && pix_ch.pixel_y == '0)
    else $error("result without a pixel carries nonzero fields");

  a_start_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && cmd_ch.ready && cmd_ch.cmd == lpg_pkg::CMD_START |=>
      s1_valid && s1_pix.pixel_valid)
    else $error("start command did not produce a pixel");
`endif

endmodule
